// ===== rtl/cslr_pkg.sv =====
package cslr_pkg;

    localparam int LINE_MAX       = 4096;
    localparam int SAMPLE_BITS    = 18;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PH_BITS        = 16;

    localparam int POS_W     = 12;
    localparam int COEF_W    = 20;
    localparam int LEN_W     = 13;
    localparam int REG_IDX_W = 2;
    localparam int STORE_W   = 3 * SAMPLE_BITS;

    // four banks interleaved on the low index bits: taps k-1..k+2 hit each bank once
    localparam int BANKS      = 4;
    localparam int BANK_W     = 2;
    localparam int BANK_DEPTH = LINE_MAX / BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // source position arithmetic
    localparam int DXY_W  = LEN_W + 2;
    localparam int PROD_W = COEF_W + DXY_W;
    localparam int M2_W   = PROD_W + 2;
    localparam int K_W    = M2_W - COEF_FRAC_BITS - 1;

    // cubic datapath
    localparam int CW   = SAMPLE_BITS + 4;
    localparam int PHS_W = PH_BITS + 1;
    localparam int P3_W = PHS_W + CW;
    localparam int S2_W = CW + PH_BITS + 2;
    localparam int P4_W = PHS_W + S2_W;
    localparam int S1_W = P4_W - PH_BITS + 1;
    localparam int P5_W = PHS_W + S1_W;
    localparam int S0_W = P5_W - PH_BITS;
    localparam int R_W  = S0_W + 1;
    localparam int RQ_W = R_W - PH_BITS - 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE,
        REG_SHEAR,
        REG_LENGTH,
        REG_COUNT
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic        [LEN_W-1:0]  len;
        logic        [LEN_W-1:0]  cnt;
    } t_cfg;

    typedef struct packed {
        logic                    is_wr;
        logic [POS_W-1:0]        pos;
        logic signed [K_W-1:0]   k;
        logic [PH_BITS-1:0]      ph;
        logic [STORE_W-1:0]      samples;
    } t_item;

endpackage

// ===== rtl/cslr_ram.sv =====
module cslr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cslr_front.sv =====
module cslr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [cslr_pkg::POS_W-1:0]    i_position,
    input  logic [cslr_pkg::POS_W-1:0]    i_row_index,
    input  logic [cslr_pkg::STORE_W-1:0]  i_samples,
    input  cslr_pkg::t_cfg                i_cfg,
    output logic                          o_push,
    output cslr_pkg::t_item               o_item,
    output logic [1:0]                    o_inflight
);

    localparam int DXY_W = cslr_pkg::DXY_W;
    localparam int PROD_W = cslr_pkg::PROD_W;
    localparam int M2_W = cslr_pkg::M2_W;
    localparam int LEN_W = cslr_pkg::LEN_W;
    localparam int POS_W = cslr_pkg::POS_W;

    logic                         r_v1, r_v2;
    logic                         r_wr1, r_wr2;
    logic [POS_W-1:0]             r_pos1, r_pos2;
    logic [cslr_pkg::STORE_W-1:0] r_smp1, r_smp2;
    logic signed [DXY_W-1:0]      r_dx, r_dy;
    logic [LEN_W-1:0]             r_lm1, r_lm2;
    logic signed [PROD_W-1:0]     r_pa, r_pb;

    logic signed [DXY_W-1:0]  n_dx, n_dy;
    logic signed [PROD_W-1:0] n_pa, n_pb;
    logic signed [M2_W-1:0]   m2;

    // centred, doubled coordinates: 2i-L+1 and 2j-H+1
    assign n_dx = $signed({{(DXY_W-POS_W-1){1'b0}}, i_position, 1'b0})
                - $signed({{(DXY_W-LEN_W){1'b0}}, i_cfg.len}) + $signed(DXY_W'(1));
    assign n_dy = $signed({{(DXY_W-POS_W-1){1'b0}}, i_row_index, 1'b0})
                - $signed({{(DXY_W-LEN_W){1'b0}}, i_cfg.cnt}) + $signed(DXY_W'(1));
    assign n_pa = i_cfg.a0 * r_dx;
    assign n_pb = i_cfg.a1 * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr1  <= (i_req_type == cslr_pkg::REQ_WRITE);
        r_pos1 <= i_position;
        r_smp1 <= i_samples;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_lm1  <= i_cfg.len - LEN_W'(1);
        r_wr2  <= r_wr1;
        r_pos2 <= r_pos1;
        r_smp2 <= r_smp1;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_lm2  <= r_lm1;
    end

    assign m2 = M2_W'(r_pa) + M2_W'(r_pb)
              + $signed(M2_W'({r_lm2, {cslr_pkg::COEF_FRAC_BITS{1'b0}}}));

    assign o_push          = r_v2;
    assign o_item.is_wr    = r_wr2;
    assign o_item.pos      = r_pos2;
    assign o_item.k        = m2[M2_W-1 -: cslr_pkg::K_W];
    assign o_item.ph       = m2[cslr_pkg::COEF_FRAC_BITS -: cslr_pkg::PH_BITS];
    assign o_item.samples  = r_smp2;
    assign o_inflight      = {1'b0, r_v1} + {1'b0, r_v2};

endmodule

// ===== rtl/cslr_queue.sv =====
module cslr_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  cslr_pkg::t_item               i_item,
    input  logic                          i_pop,
    output cslr_pkg::t_item               o_head,
    output logic                          o_nonempty,
    output logic [cslr_pkg::QCNT_W-1:0]   o_count
);

    localparam int QPTR_W = cslr_pkg::QPTR_W;
    localparam int QCNT_W = cslr_pkg::QCNT_W;

    cslr_pkg::t_item       r_mem [cslr_pkg::QDEPTH];
    logic [QPTR_W-1:0]     r_wptr, r_rptr;
    logic [QCNT_W-1:0]     r_count;
    logic                  pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

endmodule

// ===== rtl/cslr_back.sv =====
module cslr_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  cslr_pkg::t_item                       i_item,
    input  logic [cslr_pkg::LEN_W-1:0]            i_len,
    output logic                                  o_valid,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0] o_out_r,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0] o_out_g,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0] o_out_b
);

    localparam int SB      = cslr_pkg::SAMPLE_BITS;
    localparam int K_W     = cslr_pkg::K_W;
    localparam int BANK_W  = cslr_pkg::BANK_W;
    localparam int BANK_AW = cslr_pkg::BANK_AW;
    localparam int PHB     = cslr_pkg::PH_BITS;
    localparam int CW      = cslr_pkg::CW;
    localparam int P3_W    = cslr_pkg::P3_W;
    localparam int S2_W    = cslr_pkg::S2_W;
    localparam int P4_W    = cslr_pkg::P4_W;
    localparam int S1_W    = cslr_pkg::S1_W;
    localparam int P5_W    = cslr_pkg::P5_W;
    localparam int S0_W    = cslr_pkg::S0_W;
    localparam int R_W     = cslr_pkg::R_W;
    localparam int RQ_W    = cslr_pkg::RQ_W;
    localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'((1 << (SB - 1)) - 1);
    localparam logic signed [RQ_W-1:0] SAT_LO = -SAT_HI - RQ_W'(1);

    // tap addressing
    logic signed [K_W-1:0] base;
    logic signed [K_W-1:0] idx [4];
    logic [3:0]            ok;
    logic [BANK_W-1:0]     rot;
    logic [BANK_AW-1:0]    raddr [cslr_pkg::BANKS];
    logic [cslr_pkg::STORE_W-1:0] rdata [cslr_pkg::BANKS];

    always_comb begin
        base = i_item.k - K_W'(1);
        rot  = base[BANK_W-1:0];
        for (int u = 0; u < 4; u++) begin
            idx[u] = base + K_W'(u);
            ok[u]  = !idx[u][K_W-1] && (idx[u][K_W-2:0] < (K_W-1)'(i_len));
        end
        for (int b = 0; b < cslr_pkg::BANKS; b++) begin
            raddr[b] = idx[BANK_W'(BANK_W'(b) - rot)][BANK_AW+BANK_W-1:BANK_W];
        end
    end

    for (genvar b = 0; b < cslr_pkg::BANKS; b++) begin : g_bank
        cslr_ram #(
            .WIDTH (cslr_pkg::STORE_W),
            .DEPTH (cslr_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_valid && i_item.is_wr && (i_item.pos[BANK_W-1:0] == BANK_W'(b))),
            .i_waddr (i_item.pos[BANK_AW+BANK_W-1:BANK_W]),
            .i_wdata (i_item.samples),
            .i_raddr (raddr[b]),
            .o_rdata (rdata[b])
        );
    end

    // pipeline registers
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5, r_valid;
    logic [3:0]              r_ok;
    logic [BANK_W-1:0]       r_rot;
    logic [PHB-1:0]          r_ph1, r_ph2, r_ph3, r_ph4;
    logic signed [CW-1:0]    r_a2 [3], r_b2 [3], r_c2 [3];
    logic signed [CW-1:0]    r_a3 [3];
    logic signed [SB-1:0]    r_v12 [3], r_v13 [3], r_v14 [3], r_v15 [3];
    logic signed [S2_W-1:0]  r_s2 [3];
    logic signed [S1_W-1:0]  r_s1 [3];
    logic signed [S0_W-1:0]  r_s0 [3];
    logic signed [SB-1:0]    r_out [3];

    logic signed [SB-1:0]    v [3][4];
    logic signed [CW-1:0]    n_a [3], n_b [3], n_c [3];
    logic signed [P3_W-1:0]  p3 [3];
    logic signed [S2_W-1:0]  n_s2 [3];
    logic signed [P4_W-1:0]  p4 [3];
    logic signed [S1_W-1:0]  n_s1 [3];
    logic signed [P5_W-1:0]  p5 [3];
    logic signed [R_W-1:0]   t [3];
    logic signed [RQ_W-1:0]  rq [3];
    logic signed [SB-1:0]    n_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int u = 0; u < 4; u++) begin
                v[c][u] = r_ok[u] ? $signed(rdata[BANK_W'(r_rot + BANK_W'(u))][c*SB +: SB])
                                  : '0;
            end
            n_a[c] = CW'(v[c][2]) - CW'(v[c][0]);
            n_b[c] = (CW'(v[c][0]) <<< 1) - CW'(v[c][1]) * CW'(5)
                   + (CW'(v[c][2]) <<< 2) - CW'(v[c][3]);
            n_c[c] = (CW'(v[c][1]) - CW'(v[c][2])) * CW'(3) + CW'(v[c][3]) - CW'(v[c][0]);

            p3[c]   = $signed({1'b0, r_ph2}) * r_c2[c];
            n_s2[c] = (S2_W'(r_b2[c]) <<< PHB) + S2_W'(p3[c]);

            p4[c]   = $signed({1'b0, r_ph3}) * r_s2[c];
            n_s1[c] = (S1_W'(r_a3[c]) <<< PHB) + S1_W'($signed(p4[c][P4_W-1:PHB]));

            p5[c]   = $signed({1'b0, r_ph4}) * r_s1[c];

            // v1 + s/2, rounded half up, then clipped
            t[c]  = (R_W'(r_v15[c]) <<< (PHB + 1)) + R_W'(r_s0[c])
                  + $signed(R_W'(1) <<< PHB);
            rq[c] = t[c][R_W-1:PHB+1];
            if (rq[c] > SAT_HI) begin
                n_out[c] = SAT_HI[SB-1:0];
            end else if (rq[c] < SAT_LO) begin
                n_out[c] = SAT_LO[SB-1:0];
            end else begin
                n_out[c] = rq[c][SB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid && !i_item.is_wr;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok  <= ok;
        r_rot <= rot;
        r_ph1 <= i_item.ph;
        r_ph2 <= r_ph1;
        r_ph3 <= r_ph2;
        r_ph4 <= r_ph3;
        for (int c = 0; c < 3; c++) begin
            r_a2[c]  <= n_a[c];
            r_b2[c]  <= n_b[c];
            r_c2[c]  <= n_c[c];
            r_v12[c] <= v[c][1];
            r_a3[c]  <= r_a2[c];
            r_v13[c] <= r_v12[c];
            r_s2[c]  <= n_s2[c];
            r_v14[c] <= r_v13[c];
            r_s1[c]  <= n_s1[c];
            r_v15[c] <= r_v14[c];
            r_s0[c]  <= p5[c][P5_W-1:PHB];
            r_out[c] <= n_out[c];
        end
    end

    assign o_valid = r_valid;
    assign o_out_r = r_out[0];
    assign o_out_g = r_out[1];
    assign o_out_b = r_out[2];

endmodule

// ===== rtl/cubic_shear_line_resampler_core.sv =====
// Shear resampler for one image line with Catmull-Rom cubic interpolation. One request a
// cycle is taken while busy is low: a write stores an RGB sample, a compute gives one
// interpolated RGB result on o_out_* with o_valid high for exactly one cycle, after it
// passes the position unit, queue and interpolator; writes give no result. Results leave
// in request order at up to one a cycle and cannot be held off, so take them when o_valid
// is high. The one-cycle rate is set by the line store, split into four interleaved RAM
// banks so that the four neighbours of a position are read in a single cycle; the position
// multiply and the three Horner multiplies are each a pipeline stage. busy only rises if
// the request queue between the position unit and the interpolator runs short of room.
module cubic_shear_line_resampler_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     i_req_type,
    input  logic [cslr_pkg::POS_W-1:0]               i_position,
    input  logic [cslr_pkg::POS_W-1:0]               i_row_index,
    input  logic signed [cslr_pkg::SAMPLE_BITS-1:0]  i_sample_r,
    input  logic signed [cslr_pkg::SAMPLE_BITS-1:0]  i_sample_g,
    input  logic signed [cslr_pkg::SAMPLE_BITS-1:0]  i_sample_b,
    input  logic                                     i_cfg_we,
    input  logic [cslr_pkg::REG_IDX_W-1:0]           i_cfg_addr,
    input  logic [cslr_pkg::COEF_W-1:0]              i_cfg_data,
    output logic                                     o_valid,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0]  o_out_r,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0]  o_out_g,
    output logic signed [cslr_pkg::SAMPLE_BITS-1:0]  o_out_b
);

    localparam int LEN_W  = cslr_pkg::LEN_W;
    localparam int QCNT_W = cslr_pkg::QCNT_W;

    logic signed [cslr_pkg::COEF_W-1:0] r_a0, r_a1;
    logic [LEN_W-1:0]                   r_len, r_cnt;
    cslr_pkg::t_cfg                     cfg;
    logic                               accept;
    logic                               push, q_nonempty;
    cslr_pkg::t_item                    f_item, q_head;
    logic [1:0]                         inflight;
    logic [QCNT_W-1:0]                  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0  <= cslr_pkg::COEF_W'(65536);
            r_a1  <= '0;
            r_len <= LEN_W'(cslr_pkg::LINE_MAX);
            r_cnt <= LEN_W'(cslr_pkg::LINE_MAX);
        end else if (i_cfg_we) begin
            case (cslr_pkg::t_reg_idx'(i_cfg_addr))
                cslr_pkg::REG_SCALE:  r_a0  <= $signed(i_cfg_data);
                cslr_pkg::REG_SHEAR:  r_a1  <= $signed(i_cfg_data);
                cslr_pkg::REG_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                cslr_pkg::REG_COUNT:  r_cnt <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp length to 1..LINE_MAX and count to at least 1
    always_comb begin
        cfg.a0 = r_a0;
        cfg.a1 = r_a1;
        if (r_len == '0) begin
            cfg.len = LEN_W'(1);
        end else if (r_len > LEN_W'(cslr_pkg::LINE_MAX)) begin
            cfg.len = LEN_W'(cslr_pkg::LINE_MAX);
        end else begin
            cfg.len = r_len;
        end
        cfg.cnt = (r_cnt == '0) ? LEN_W'(1) : r_cnt;
    end

    assign busy   = (q_count + QCNT_W'(inflight)) >= QCNT_W'(cslr_pkg::QDEPTH);
    assign accept = start && !busy;

    cslr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_row_index (i_row_index),
        .i_samples   ({i_sample_b, i_sample_g, i_sample_r}),
        .i_cfg       (cfg),
        .o_push      (push),
        .o_item      (f_item),
        .o_inflight  (inflight)
    );

    cslr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (f_item),
        .i_pop      (q_nonempty),
        .o_head     (q_head),
        .o_nonempty (q_nonempty),
        .o_count    (q_count)
    );

    cslr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_nonempty),
        .i_item  (q_head),
        .i_len   (cfg.len),
        .o_valid (o_valid),
        .o_out_r (o_out_r),
        .o_out_g (o_out_g),
        .o_out_b (o_out_b)
    );

endmodule

// ===== rtl/cslr_checker.sv =====
module cslr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid
);

    logic [3:0] r_run;
    logic       comp_acc;

    // count clean cycles since reset, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (r_run != 4'hF) begin
            r_run <= r_run + 4'd1;
        end
    end

    assign comp_acc = i_rst_n && start && !busy && (i_req_type == cslr_pkg::REQ_COMPUTE);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run >= 4'd9 && $past(comp_acc, 9)) |-> o_valid)
        else $error("compute request gave no result after nine cycles");

    a_result_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run >= 4'd9 && o_valid) |-> $past(comp_acc, 9))
        else $error("result without a matching compute request");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind cubic_shear_line_resampler_core cslr_checker u_cslr_checker (.*);
